// ===== sv/urid_pkg.sv =====
// Package for the unique random id draw unit.
// Pool size, field widths and derived index widths; no dependencies.
`timescale 1ns / 1ps

package urid_pkg;

  localparam int POOL_SIZE = 256;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);
  localparam int ID_W      = 9;
  localparam int RAND_W    = 31;
  localparam int STEP_W    = $clog2(RAND_W);
  localparam int IN_TDATA_W  = ((RAND_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

endpackage

// ===== sv/urid_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module urid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/urid_mod.sv =====
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on urid_pkg.
`timescale 1ns / 1ps

module urid_mod import urid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [CNT_W-1:0]  remainder
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RAND_W-1:0] shreg;
  logic [CNT_W:0]    trial;

  assign trial = {remainder, shreg[RAND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(RAND_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      remainder <= '0;
    end else if (busy) begin
      shreg <= {shreg[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        remainder <= CNT_W'(trial - {1'b0, divisor});
      end else begin
        remainder <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

// ===== sv/unique_random_id_draw_unit.sv =====
// Unique random id draw unit: hands out ids 1..POOL_SIZE in random order.
// Depends on urid_pkg, urid_mod and urid_ram.
`timescale 1ns / 1ps
//
// Usage:
//   Input stream s_axis carries one 31-bit random value per item. Each item
//   yields one result item on m_axis: the drawn id in tdata, and in tuser a
//   flag that is set when the pool was already empty (id is then 0).
//   The random value is reduced modulo the remaining count by a bit-serial
//   remainder unit, then the pool RAM is read twice through its read port and
//   written once; an empty-pool item goes straight to the output register.
//   s_axis_tready is low while an item is being worked on.
//   The result sits in an output register, so the next item is accepted
//   while a result still waits; if the receiver stalls long enough the unit
//   holds its finished result and stays busy until the register frees up.
//   Reset makes slot i hold i+1 at once through per-slot valid bits (an
//   unwritten slot reads as its index plus one) and sets the count to
//   POOL_SIZE; no clearing pass is needed.

module unique_random_id_draw_unit import urid_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [30:0] random_value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [8:0] identifier
  output logic [0:0]             m_axis_tuser    // [0] exhausted
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MOD     = 6'b000010,
    ST_RD_SLOT = 6'b000100,
    ST_RD_LAST = 6'b001000,
    ST_WRITE   = 6'b010000,
    ST_OUT     = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    last_full;
  logic [SLOT_W-1:0]   last;
  logic [SLOT_W-1:0]   slot;
  logic [POOL_SIZE-1:0] vld;
  logic                vld_q;
  logic [SLOT_W-1:0]   raddr;
  logic [ID_W-1:0]     rdata;
  logic [ID_W-1:0]     wdata;
  logic                we;
  logic [ID_W-1:0]     res_id;
  logic                res_exh;
  logic                in_acc;
  logic                mod_start;
  logic                mod_done;
  logic [CNT_W-1:0]    mod_rem;
  logic                out_free;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign mod_start     = in_acc && (count != '0);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign last_full     = count - 1'b1;
  assign last          = last_full[SLOT_W-1:0];
  assign raddr         = (state == ST_RD_SLOT) ? slot : last;
  assign we            = (state == ST_WRITE);
  assign wdata         = vld_q ? rdata : ID_W'({1'b0, last} + 1'b1);

  urid_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (s_axis_tdata[RAND_W-1:0]),
    .divisor   (count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  urid_ram #(
    .WIDTH (ID_W),
    .DEPTH (POOL_SIZE)
  ) u_pool (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (count == '0) ? ST_OUT : ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_RD_SLOT;
        end
      end
      ST_RD_SLOT: state_next = ST_RD_LAST;
      ST_RD_LAST: state_next = ST_WRITE;
      ST_WRITE:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= CNT_W'(POOL_SIZE);
      vld           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WRITE) begin
        vld[slot] <= 1'b1;
        count     <= last_full;
      end
      if (state == ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= vld[raddr];
    if (mod_done) begin
      slot <= mod_rem[SLOT_W-1:0];
    end
    if (in_acc) begin
      res_id  <= '0;
      res_exh <= (count == '0);
    end else if (state == ST_RD_LAST) begin
      res_id <= vld_q ? rdata : ID_W'({1'b0, slot} + 1'b1);
    end
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= OUT_TDATA_W'(res_id);
      m_axis_tuser <= res_exh;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for unique_random_id_draw_unit: random draws against a pool tracker.
// Depends on urid_pkg and the unit's RTL; stalls on both sides at random.
`timescale 1ns / 1ps

module tb_top;
  import urid_pkg::*;

  localparam int DIRECTED = 18;
  localparam int NUM_ITEMS = 750;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            exhausted;
  } draw_result_t;

  // Mirror of the id pool; one expected draw per accepted item.
  class id_draw_tracker;
    logic [ID_W-1:0] pool [POOL_SIZE];
    int unsigned     remaining;
    draw_result_t    pending_draws[$];
    int              fails;

    function new();
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = ID_W'(i + 1);
      remaining = POOL_SIZE;
      fails = 0;
    endfunction

    function void note_draw(logic [RAND_W-1:0] rv);
      int unsigned  slot;
      draw_result_t r;
      if (remaining == 0) begin
        r.id = '0;
        r.exhausted = 1'b1;
      end else begin
        slot = rv % remaining;
        r.id = pool[slot];
        r.exhausted = 1'b0;
        pool[slot] = pool[remaining - 1];
        remaining--;
      end
      pending_draws.push_back(r);
    endfunction

    function void check_draw(logic [ID_W-1:0] id, logic exhausted);
      draw_result_t e;
      if (pending_draws.size() == 0) begin
        $error("unexpected result item: identifier %0d exhausted %0d", id, exhausted);
        fails++;
        return;
      end
      e = pending_draws.pop_front();
      if (id !== e.id) begin
        $error("identifier mismatch: expected %0d, got %0d", e.id, id);
        fails++;
      end
      if (exhausted !== e.exhausted) begin
        $error("exhausted mismatch: expected %0d, got %0d", e.exhausted, exhausted);
        fails++;
      end
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   steady;

  id_draw_tracker tracker = new();

  unique_random_id_draw_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) tracker.note_draw(s_axis_tdata[RAND_W-1:0]);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_draw(m_axis_tdata[ID_W-1:0], m_axis_tuser[0]);
  end

  always @(negedge clk) begin
    m_axis_tready = !rst && (steady || $urandom_range(0, 99) >= 14);
  end

  // Mostly full-range values; some small, some that land on the last slot.
  function automatic logic [RAND_W-1:0] pick_random_value(int unsigned left);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return RAND_W'($urandom);
    if (sel < 70) return RAND_W'($urandom_range(0, 600));
    if (sel < 85 && left != 0) return RAND_W'($urandom_range(0, 1000) * left + left - 1);
    if (sel < 93) return RAND_W'(1) << $urandom_range(0, RAND_W - 1);
    return ~(RAND_W'(1) << $urandom_range(0, RAND_W - 1));
  endfunction

  // Directed values: field extremes, bit patterns, last-slot and first-slot picks.
  function automatic logic [RAND_W-1:0] directed_value(int n, int unsigned left);
    case (n)
      0: return '0;
      1: return '1;
      2: return RAND_W'(left - 1);
      3: return RAND_W'(left);
      4: return RAND_W'(1);
      5: return RAND_W'(32'h5555_5555);
      6: return RAND_W'(32'h2AAA_AAAA);
      7: return RAND_W'(32'h4000_0000);
      8: return RAND_W'(255);
      9: return RAND_W'(256);
      10: return RAND_W'(511);
      11: return RAND_W'(left * 1000 + left - 1);
      12: return RAND_W'(32'h7FFF_FF00);
      13: return RAND_W'(32'h0000_FFFF);
      14: return RAND_W'(32'h7FFF_0000);
      15: return RAND_W'(left - 1);
      16: return RAND_W'(2 * left);
      default: return RAND_W'(32'h7FFF_FFFE);
    endcase
  endfunction

  task automatic send_draw(input logic [RAND_W-1:0] rv);
    while (!steady && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = IN_TDATA_W'(RAND_W'($urandom));
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = IN_TDATA_W'(rv);
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    steady = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (i == DIRECTED || i == 400) drain_results();
      steady = (i >= 300 && i < 450);
      if (i < DIRECTED) send_draw(directed_value(i, tracker.remaining));
      else send_draw(pick_random_value(tracker.remaining));
    end
    s_axis_tvalid = 1'b0;
    steady = 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/urid_pkg.sv
sv/urid_ram.sv
sv/urid_mod.sv
sv/unique_random_id_draw_unit.sv
tb/tb_top.sv
